// ===== src/button_click_classifier_unit_macros.svh =====
// Assertion helpers shared by the button click classifier modules.
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BCC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BCC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/bcc_pkg.sv =====
`default_nettype none

package bcc_pkg;

   // Width of the press, window and duration counters.
   localparam int COUNT_WIDTH = 16;
   // Width used to compare counters against the 16-bit thresholds.
   localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam int STABLE_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [STABLE_WIDTH-1:0] STABLE_MAX = {STABLE_WIDTH{1'b1}};

   // Register reset values.
   localparam logic [7:0] DEBOUNCE_RESET = 8'd25;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
   localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd300;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOUBLE_CLICK = 2'd2;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_SINGLE = 2'd1,
      KIND_DOUBLE = 2'd2,
      KIND_LONG = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] debounce_ticks;
      logic [15:0] long_press_ticks;
      logic [15:0] double_click_ticks;
   } cfg_type;

   typedef struct packed {
      logic event_valid;
      kind_type event_kind;
      logic [15:0] last_press_ticks;
      logic clean_level;
      logic [15:0] held_ticks;
   } result_type;

endpackage

`default_nettype wire

// ===== src/button_click_classifier_unit.sv =====
// Path: an accepted request waits in the request register until the response
// register is free or draining, and its response is then shown on rsp_valid.
// Throughput: one request per cycle unless rsp_stall holds the response; the
// whole tick update is one registered pass between the request register and the response register.
// Reset: synchronous, active high; it clears all timing state and the latched
// event and loads the register defaults of 25, 1000 and 300 ticks.
`default_nettype none

`include "button_click_classifier_unit_macros.svh"

module button_click_classifier_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic req_raw_level,
   input wire logic req_ack,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic rsp_event_valid,
   output logic [1:0] rsp_event_kind,
   output logic [15:0] rsp_last_press_ticks,
   output logic rsp_clean_level,
   output logic [15:0] rsp_held_ticks,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [bcc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input wire logic [bcc_pkg::CSR_DATA_WIDTH-1:0] csr_data
);

   bcc_pkg::cfg_type cfg;
   bcc_pkg::result_type result;

   logic in_valid_ff, in_valid_in;
   logic in_raw_ff, in_raw_in;
   logic in_ack_ff, in_ack_in;
   logic out_valid_ff, out_valid_in;
   bcc_pkg::result_type rsp_ff, rsp_in;
   logic fire;
   logic req_take;

   bcc_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cfg(cfg)
   );

   bcc_core u_core (
      .clock(clock),
      .reset(reset),
      .step(fire),
      .raw_level(in_raw_ff),
      .ack(in_ack_ff),
      .cfg(cfg),
      .result(result)
   );

   // A held request moves on whenever the response register is free or draining.
   assign fire = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take = req_valid && !req_stall;

   // Request register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_raw_in = in_raw_ff;
      in_ack_in = in_ack_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_raw_in = req_raw_level;
         in_ack_in = req_ack;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Response register.
   always_comb begin
      out_valid_in = out_valid_ff;
      rsp_in = rsp_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         rsp_in = result;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_raw_ff <= in_raw_in;
      in_ack_ff <= in_ack_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_event_valid = rsp_ff.event_valid;
   assign rsp_event_kind = rsp_ff.event_kind;
   assign rsp_last_press_ticks = rsp_ff.last_press_ticks;
   assign rsp_clean_level = rsp_ff.clean_level;
   assign rsp_held_ticks = rsp_ff.held_ticks;

   // An accepted request is always held in the request register next cycle.
   `BCC_ASSERT_NXT(a_take_fills, clock, reset, req_take, in_valid_ff,
      "accepted request was not captured")
   // A processed tick always produces a response next cycle.
   `BCC_ASSERT_NXT(a_fire_responds, clock, reset, fire, rsp_valid,
      "processed tick produced no response")
   // A request that cannot move on is kept.
   `BCC_ASSERT_NXT(a_blocked_holds, clock, reset, in_valid_ff && !fire,
      in_valid_ff && $stable(in_raw_ff) && $stable(in_ack_ff),
      "blocked request was lost")

endmodule

`default_nettype wire

// ===== src/bcc_csr.sv =====
`default_nettype none

module bcc_csr (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [bcc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input wire logic [bcc_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   output bcc_pkg::cfg_type cfg
);

   bcc_pkg::cfg_type cfg_ff;
   bcc_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   // Decode the register index; unknown indexes leave everything unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bcc_pkg::CSR_DEBOUNCE: cfg_in.debounce_ticks = csr_data[7:0];
            bcc_pkg::CSR_LONG_PRESS: cfg_in.long_press_ticks = csr_data[15:0];
            bcc_pkg::CSR_DOUBLE_CLICK: cfg_in.double_click_ticks = csr_data[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= bcc_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= bcc_pkg::LONG_PRESS_RESET;
         cfg_ff.double_click_ticks <= bcc_pkg::DOUBLE_CLICK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bcc_core.sv =====
`default_nettype none

`include "button_click_classifier_unit_macros.svh"

module bcc_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic step,
   input wire logic raw_level,
   input wire logic ack,
   input wire bcc_pkg::cfg_type cfg,
   output bcc_pkg::result_type result
);

   logic stable_level_ff, stable_level_in;
   logic raw_previous_ff, raw_previous_in;
   logic [bcc_pkg::STABLE_WIDTH-1:0] stable_count_ff, stable_count_in;
   bcc_pkg::count_type press_count_ff, press_count_in;
   bcc_pkg::count_type since_click_count_ff, since_click_count_in;
   logic waiting_ff, waiting_in;
   bcc_pkg::kind_type latched_kind_ff, latched_kind_in;
   logic latched_valid_ff, latched_valid_in;
   bcc_pkg::count_type last_duration_ff, last_duration_in;
   logic rose;
   logic fell;

   function automatic bcc_pkg::count_type sat_inc(input bcc_pkg::count_type v);
      return (v != bcc_pkg::CNT_MAX) ? v + 1'b1 : bcc_pkg::CNT_MAX;
   endfunction

   // Next state for one tick.
   always_comb begin
      stable_level_in = stable_level_ff;
      raw_previous_in = raw_previous_ff;
      stable_count_in = stable_count_ff;
      press_count_in = press_count_ff;
      since_click_count_in = since_click_count_ff;
      waiting_in = waiting_ff;
      latched_kind_in = latched_kind_ff;
      latched_valid_in = latched_valid_ff;
      last_duration_in = last_duration_ff;

      // Acknowledge clears the latched event first.
      if (ack) begin
         latched_valid_in = 1'b0;
         latched_kind_in = bcc_pkg::KIND_NONE;
      end

      // Debouncer: restart the stable interval on any raw change.
      if (raw_level != raw_previous_ff) begin
         raw_previous_in = raw_level;
         stable_count_in = '0;
      end else if (stable_count_ff != bcc_pkg::STABLE_MAX) begin
         stable_count_in = stable_count_ff + 1'b1;
      end
      if ((raw_previous_in != stable_level_ff) && (stable_count_in >= cfg.debounce_ticks)) begin
         stable_level_in = raw_previous_in;
      end

      rose = !stable_level_ff && stable_level_in;
      fell = stable_level_ff && !stable_level_in;

      // Press timing.
      if (rose) begin
         press_count_in = '0;
      end else if (stable_level_ff) begin
         press_count_in = sat_inc(press_count_ff);
      end

      // Double-click window timing.
      if (waiting_ff) begin
         since_click_count_in = sat_inc(since_click_count_ff);
      end

      // Classify the press on release.
      if (fell) begin
         last_duration_in = press_count_in;
         if (bcc_pkg::CMP_WIDTH'(press_count_in) >=
             bcc_pkg::CMP_WIDTH'(cfg.long_press_ticks)) begin
            latched_kind_in = bcc_pkg::KIND_LONG;
            latched_valid_in = 1'b1;
         end else if (waiting_ff && (bcc_pkg::CMP_WIDTH'(since_click_count_in) <=
                                     bcc_pkg::CMP_WIDTH'(cfg.double_click_ticks))) begin
            latched_kind_in = bcc_pkg::KIND_DOUBLE;
            latched_valid_in = 1'b1;
            waiting_in = 1'b0;
         end else begin
            latched_kind_in = bcc_pkg::KIND_SINGLE;
            latched_valid_in = 1'b1;
            waiting_in = 1'b1;
            since_click_count_in = '0;
         end
      end

      // Close the window once the gap has run past the limit.
      if (waiting_in && (bcc_pkg::CMP_WIDTH'(since_click_count_in) >
                         bcc_pkg::CMP_WIDTH'(cfg.double_click_ticks))) begin
         waiting_in = 1'b0;
      end
   end

   // The result shows the state after this tick.
   always_comb begin
      result.event_valid = latched_valid_in;
      result.event_kind = latched_valid_in ? latched_kind_in : bcc_pkg::KIND_NONE;
      result.last_press_ticks = 16'(last_duration_in);
      result.clean_level = stable_level_in;
      result.held_ticks = stable_level_in ? 16'(press_count_in) : 16'd0;
   end

   // State advances only when a tick is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_level_ff <= 1'b0;
         raw_previous_ff <= 1'b0;
         stable_count_ff <= '0;
         press_count_ff <= '0;
         since_click_count_ff <= '0;
         waiting_ff <= 1'b0;
         latched_kind_ff <= bcc_pkg::KIND_NONE;
         latched_valid_ff <= 1'b0;
         last_duration_ff <= '0;
      end else if (step) begin
         stable_level_ff <= stable_level_in;
         raw_previous_ff <= raw_previous_in;
         stable_count_ff <= stable_count_in;
         press_count_ff <= press_count_in;
         since_click_count_ff <= since_click_count_in;
         waiting_ff <= waiting_in;
         latched_kind_ff <= latched_kind_in;
         latched_valid_ff <= latched_valid_in;
         last_duration_ff <= last_duration_in;
      end
   end

   // A latched event always carries a kind, and no kind is held without one.
   `BCC_ASSERT_IMP(a_kind_matches_valid, clock, reset, 1'b1,
      latched_valid_ff == (latched_kind_ff != bcc_pkg::KIND_NONE),
      "latched kind disagrees with latched valid")
   // A release always latches an event and records its press length.
   `BCC_ASSERT_NXT(a_release_latches, clock, reset, step && fell,
      latched_valid_ff && (last_duration_ff == $past(press_count_in)),
      "release did not latch an event")
   // Without a tick the timing state holds.
   `BCC_ASSERT_NXT(a_idle_holds, clock, reset, !step,
      $stable(press_count_ff) && $stable(stable_level_ff) && $stable(since_click_count_ff),
      "state changed without a tick")

endmodule

`default_nettype wire
